// File: hdl/mmpr_pkg.sv
// ----------------------------------------------------------------------------
// mmpr_pkg: shared types and constants for the PWM ramp block
// Field widths, level table reset values, divider handshake structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mmpr_pkg;

  localparam int DUTY_W   = 10;
  localparam int STEP_W   = 13;
  localparam int RAMP_W   = 16;
  localparam int LEVEL_W  = 3;
  localparam int DIR_W    = 2;
  localparam int CFG_IW   = 3;
  localparam int LEVELS   = 5;

  // Divider dividend is the largest channel distance
  localparam int DIVD_W   = DUTY_W;
  localparam int DCNT_W   = $clog2(DIVD_W + 1);

  // Ramp time plus the rounding offset
  localparam int RND_W    = RAMP_W + 1;

  // Step count = (ramp + 5) / 10 as (ramp + 5) * ceil(2^19 / 10) >> 19,
  // exact for every rounded ramp time below 2^18
  localparam int RECIP_W  = 16;
  localparam int RECIP_SH = 19;
  localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'(52429);

  localparam logic [RAMP_W-1:0] DEFAULT_RAMP_MS = RAMP_W'(200);
  localparam logic [STEP_W-1:0] TICK_MS         = STEP_W'(10);
  localparam logic [RND_W-1:0]  TICK_HALF       = RND_W'(5);

  localparam logic [DIR_W-1:0]  DIR_BACKWARD    = 2'd2;

  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef logic [DUTY_W-1:0] duty_t;

  localparam duty_t LEVEL_RESET [LEVELS] = '{
    duty_t'(1000), duty_t'(750), duty_t'(500), duty_t'(300), duty_t'(100)
  };

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [STEP_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
    logic [STEP_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: hdl/multi_motor_pwm_ramp.sv
// ----------------------------------------------------------------------------
// multi_motor_pwm_ramp: soft-start ramp for a group of PWM channels
// Speed commands plan a ramp toward a table duty; ticks step every channel while steps remain.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Payload
//  s_*      in         s_tvalid/s_tready  tuser operation, tdata level/dir/ramp
//  m_*      out        m_tvalid/m_tready  tdata duties + reverse, tlast last_step
//  cfg_*    in         cfg_we             cfg_index, cfg_data (level table)
//
//  Timing: a tick beat runs one channel per cycle through the shared
//  distance/step unit, then the result load. A speed command runs the
//  distance scan, a launch state and the 10-bit serial divider (distance
//  over steps); the step count itself comes from the ramp time by a
//  reciprocal multiply at accept.
//  s_tready is high only while the sequencer is idle and out of reset.
//  A finished result waits in the output register; a following tick is
//  taken meanwhile and holds at its own result load until m_tready frees
//  the register.
//  Reset (rst, synchronous) zeroes the duties and ramp state and reloads
//  the level table; it acts on the rising clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_motor_pwm_ramp #(
  parameter int CHANNELS = 3
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // slave stream
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // [2:0] level, [4:3] move_direction, [20:5] ramp_time_ms, [23:21] zero
  input  wire logic [23:0]                    s_tdata,
  // [0] operation
  input  wire logic                           s_tuser,
  // master stream
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [9:0] duty_zero, [19:10] duty_one, [29:20] duty_two, [30] reverse, [31] zero
  output logic [31:0]                         m_tdata,
  output logic                                m_tlast,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [mmpr_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [mmpr_pkg::DUTY_W-1:0]    cfg_data
);
  import mmpr_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAXD  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_TICK  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]         state;

  // level table
  duty_t              duty_reg [LEVELS];

  // ramp state
  duty_t              channel_duty [CHANNELS];
  duty_t              target_duty;
  logic [STEP_W-1:0]  steps_left;
  duty_t              base_increment;
  logic [STEP_W-1:0]  extra_left;
  logic               direction_bit;

  // per-item working registers
  logic [CH_W-1:0]    ch;
  duty_t              max_dist;
  logic [DUTY_W:0]    inc;
  logic               last;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // input fields
  logic [LEVEL_W-1:0] in_level;
  logic [DIR_W-1:0]   in_dir;
  logic [RAMP_W-1:0]  in_ramp;
  logic               in_accept;
  logic               level_ok;

  assign in_level  = s_tdata[2:0];
  assign in_dir    = s_tdata[4:3];
  assign in_ramp   = s_tdata[20:5];
  assign s_tready  = (state == S_IDLE) && !rst;
  assign in_accept = s_tvalid && s_tready;
  assign level_ok  = (in_level >= LEVEL_W'(1)) && (in_level <= LEVEL_W'(LEVELS));

  // step count: rounded ramp time over the tick period, zero rounds up to one
  logic [RND_W-1:0]          ramp_rnd;
  logic [RND_W+RECIP_W-1:0]  ramp_prod;
  logic [STEP_W-1:0]         steps_raw;
  logic [STEP_W-1:0]         steps_in;

  assign ramp_rnd  = RND_W'((in_ramp == '0) ? DEFAULT_RAMP_MS : in_ramp) + TICK_HALF;
  assign ramp_prod = ramp_rnd * RECIP_TEN;
  assign steps_raw = STEP_W'(ramp_prod >> RECIP_SH);
  assign steps_in  = (steps_raw == '0) ? STEP_W'(1) : steps_raw;

  // shared distance / step unit, fed with the channel under the counter
  duty_t cur_duty;
  duty_t gap;
  logic  below;
  duty_t stepped;

  assign cur_duty = channel_duty[ch];
  assign below    = cur_duty < target_duty;
  assign gap      = below ? duty_t'(target_duty - cur_duty)
                          : duty_t'(cur_duty - target_duty);
  always_comb begin
    if (last || ({1'b0, gap} <= inc)) begin
      stepped = target_duty;
    end else if (below) begin
      stepped = duty_t'({1'b0, cur_duty} + inc);
    end else begin
      stepped = duty_t'({1'b0, cur_duty} - inc);
    end
  end

  // divider launch: largest distance over the step count
  always_comb begin
    div_req = '0;
    unique case (state)
      S_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = max_dist;
        div_req.divisor  = steps_left;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  mmpr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // result load once the output register is free
  logic emit_go;
  assign emit_go = (state == S_EMIT) && (!m_tvalid || m_tready);

  // level table writes; indexes past the table are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        duty_reg[i] <= LEVEL_RESET[i];
      end
    end else if (cfg_we && (cfg_index < CFG_IW'(LEVELS))) begin
      duty_reg[cfg_index] <= cfg_data;
    end
  end

  // sequencer and ramp state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      for (int i = 0; i < CHANNELS; i++) begin
        channel_duty[i] <= '0;
      end
      target_duty    <= '0;
      steps_left     <= '0;
      base_increment <= '0;
      extra_left     <= '0;
      direction_bit  <= 1'b0;
      ch             <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // raise on a loaded result, drop once the sink takes it
      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            ch <= '0;
            if (s_tuser == OP_COMMAND) begin
              if (level_ok) begin
                // latch direction, target and step count, then scan distances
                direction_bit <= (in_dir == DIR_BACKWARD);
                target_duty   <= duty_reg[in_level - LEVEL_W'(1)];
                steps_left    <= steps_in;
                max_dist      <= '0;
                state         <= S_MAXD;
              end
            end else if (steps_left != '0) begin
              // consume one step of the plan, with one extra while it lasts
              inc        <= {1'b0, base_increment} + (DUTY_W + 1)'(extra_left != '0);
              if (extra_left != '0) begin
                extra_left <= extra_left - 1'b1;
              end
              steps_left <= steps_left - 1'b1;
              last       <= (steps_left == STEP_W'(1));
              state      <= S_TICK;
            end
          end
        end

        S_MAXD: begin
          if (gap > max_dist) begin
            max_dist <= gap;
          end
          ch <= ch + 1'b1;
          if (ch == CH_LAST) begin
            if (max_dist == '0 && gap == '0) begin
              // already at target: no ramp
              steps_left     <= '0;
              base_increment <= '0;
              extra_left     <= '0;
              state          <= S_IDLE;
            end else begin
              state <= S_START;
            end
          end
        end

        S_START: begin
          state <= S_DIV;
        end

        S_DIV: begin
          if (div_rsp.done) begin
            base_increment <= div_rsp.quotient[DUTY_W-1:0];
            extra_left     <= div_rsp.remainder;
            state          <= S_IDLE;
          end
        end

        S_TICK: begin
          channel_duty[ch] <= stepped;
          ch <= ch + 1'b1;
          if (ch == CH_LAST) begin
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          // hold until the output register is free
          if (emit_go) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result fields; channels not present read as zero
  duty_t out_duty [3];

  for (genvar g = 0; g < 3; g++) begin : g_out
    if (g < CHANNELS) begin : g_on
      assign out_duty[g] = channel_duty[g];
    end else begin : g_off
      assign out_duty[g] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      m_tdata <= {1'b0, direction_bit, out_duty[2], out_duty[1], out_duty[0]};
      m_tlast <= last;
    end
  end

endmodule

`default_nettype wire

// File: hdl/mmpr_div.sv
// ----------------------------------------------------------------------------
// mmpr_div: serial restoring divider
// One quotient bit per cycle; done pulses high for a single cycle, registered together with the last bit.
// ----------------------------------------------------------------------------
`default_nettype none

module mmpr_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mmpr_pkg::div_req_t req,
  output mmpr_pkg::div_rsp_t     rsp
);
  import mmpr_pkg::*;

  logic [DIVD_W-1:0] quo;
  logic [STEP_W-1:0] rem;
  logic [STEP_W-1:0] dvs;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [STEP_W:0]   trial;
  logic              fits;

  assign trial = {rem, quo[DIVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DIVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      // shift in the next dividend bit, subtract if it fits
      rem <= fits ? STEP_W'(trial - {1'b0, dvs}) : trial[STEP_W-1:0];
      quo <= {quo[DIVD_W-2:0], fits};
    end
  end

  assign rsp = {done, quo, rem};

endmodule

`default_nettype wire
